### hdl/cdf_pkg.sv
package cdf_pkg;

    localparam int SampleW = 32;
    localparam int ActionW = 2;
    localparam int StatusW = 2;

    localparam logic [ActionW-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ActionW-1:0] ACT_ADD   = 2'd1;
    localparam logic [ActionW-1:0] ACT_QUERY = 2'd2;
    localparam logic [ActionW-1:0] ACT_NOP   = 2'd3;

    localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
    localparam logic [StatusW-1:0] STATUS_FULL  = 2'd1;
    localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd2;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic insert;
        logic probe;
    } t_cell_op;

endpackage

### hdl/cdf_cell.sv
module cdf_cell #(
    parameter int RANK_W = 9
) (
    input  logic                   i_clk,
    input  cdf_pkg::t_cell_op      i_op,
    input  logic [31:0]            i_key,
    input  logic                   i_valid,
    input  logic                   i_left_valid,
    input  logic                   i_left_gt,
    input  logic [31:0]            i_left_sample,
    input  logic                   i_right_le,
    input  logic [RANK_W-1:0]      i_rank,
    output logic [31:0]            o_sample,
    output logic                   o_gt,
    output logic                   o_le,
    output logic [RANK_W-1:0]      o_word
);
    import cdf_pkg::*;

    logic [SampleW-1:0] r_sample;
    logic               r_le;
    logic               take;

    assign o_gt = i_valid && ($signed(r_sample) > $signed(i_key));

    // a new sample lands in the first cell holding a larger one, or in the
    // first empty cell; everything above moves one cell right
    assign take = i_op.insert && (o_gt || (!i_valid && i_left_valid));

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_sample <= i_left_gt ? i_left_sample : i_key;
        end
        if (i_op.probe) begin
            r_le <= i_valid && !o_gt;
        end
    end

    // only the last cell at or below the key reports its rank
    assign o_word   = (r_le && !i_right_le) ? i_rank : '0;
    assign o_sample = r_sample;
    assign o_le     = r_le;

endmodule

### hdl/cdf_div.sv
module cdf_div #(
    parameter int CNT_W  = 9,
    parameter int FRAC_W = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [CNT_W-1:0]  i_count,
    input  logic [CNT_W-1:0]  i_total,
    output logic              o_done,
    output logic              o_busy,
    output logic [FRAC_W:0]   o_quot
);
    import cdf_pkg::*;

    localparam int StepW = $clog2(FRAC_W + 2);

    logic [CNT_W:0]   r_rem;
    logic [FRAC_W:0]  r_quot;
    logic [StepW-1:0] r_step;
    logic             r_busy;
    logic             r_done;
    logic             ge;
    logic [CNT_W:0]   diff;

    // one quotient bit per cycle, most significant (the 1.0 bit) first
    assign ge   = r_rem >= {1'b0, i_total};
    assign diff = ge ? (r_rem - {1'b0, i_total}) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= {1'b0, i_count};
            end else if (r_busy) begin
                r_quot <= {r_quot[FRAC_W-1:0], ge};
                r_rem  <= {diff[CNT_W-1:0], 1'b0};
                r_step <= r_step + 1'b1;
                if (r_step == StepW'(FRAC_W)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

### hdl/empirical_cdf_query_core.sv
// Clear, add and no-op words pass from the input register through the execute and done
// states to the output register; a query also passes through the registered OR fold over
// the cell row and the bit-serial divider. One word is in flight at a time: a new word is
// taken only in the idle state, after the last result has gone to the output register.
// Synchronous active-low reset empties the set.
module empirical_cdf_query_core #(
    parameter int CAPACITY      = 256,
    parameter int FRACTION_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [31:0]          i_s_tdata,   // [31:0] value
    input  logic [1:0]           i_s_tuser,   // [1:0] action
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [CW-1:0] count_at_or_below, then fraction (FRACTION_BITS+1), zero fill
    output logic [((($clog2(CAPACITY+1))+FRACTION_BITS+1+7)/8)*8-1:0] o_m_tdata,
    output logic [1:0]           o_m_tuser    // [1:0] status
);
    import cdf_pkg::*;

    function automatic int fold_steps(input int n);
        int s;
        int span;
        s    = 0;
        span = 1;
        while (span < n) begin
            span = span * 8;
            s++;
        end
        return s;
    endfunction

    localparam int CW        = $clog2(CAPACITY + 1);
    localparam int FB        = FRACTION_BITS;
    localparam int OutDataW  = ((CW + FB + 1 + 7) / 8) * 8;
    localparam int FoldSteps = fold_steps(CAPACITY);
    localparam int FoldW     = $clog2(FoldSteps + 1);
    localparam int Groups    = (CAPACITY + 7) / 8;

    typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_FOLD, ST_DIV, ST_DONE} t_state;

    t_state             r_state;
    logic [ActionW-1:0] r_action;
    logic [SampleW-1:0] r_key;
    logic [CW-1:0]      r_total;
    logic [FoldW-1:0]   r_fold;
    logic [StatusW-1:0] r_res_status;
    logic [CW-1:0]      r_res_count;
    logic [FB:0]        r_res_frac;
    logic               r_out_valid;
    logic [StatusW-1:0] r_out_status;
    logic [CW-1:0]      r_out_count;
    logic [FB:0]        r_out_frac;

    logic [CW-1:0]      r_acc [CAPACITY];
    logic [CW-1:0]      n_acc [CAPACITY];
    logic [CW-1:0]      fold_src [CAPACITY];

    logic [SampleW-1:0] w_sample [CAPACITY];
    logic               w_gt     [CAPACITY];
    logic               w_le     [CAPACITY];
    logic               w_valid  [CAPACITY];
    logic [CW-1:0]      w_word   [CAPACITY];

    t_cell_op           cell_op;
    logic               full;
    logic               div_start;
    logic               div_done;
    logic               div_busy;
    logic [FB:0]        div_quot;
    logic               out_free;

    assign full     = r_total == CW'(CAPACITY);
    assign out_free = !r_out_valid || i_m_tready;

    assign cell_op.insert = (r_state == ST_EXEC) && (r_action == ACT_ADD) && !full;
    assign cell_op.probe  = (r_state == ST_EXEC) && (r_action == ACT_QUERY);

    // ---------------- cell row ----------------
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic               left_valid;
        logic               left_gt;
        logic [SampleW-1:0] left_sample;
        logic               right_le;

        assign w_valid[i] = CW'(i) < r_total;

        if (i == 0) begin : g_first
            assign left_valid  = 1'b1;
            assign left_gt     = 1'b0;
            assign left_sample = '0;
        end else begin : g_mid
            assign left_valid  = w_valid[i-1];
            assign left_gt     = w_gt[i-1];
            assign left_sample = w_sample[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_le = 1'b0;
        end else begin : g_inner
            assign right_le = w_le[i+1];
        end

        cdf_cell #(
            .RANK_W (CW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_op          (cell_op),
            .i_key         (r_key),
            .i_valid       (w_valid[i]),
            .i_left_valid  (left_valid),
            .i_left_gt     (left_gt),
            .i_left_sample (left_sample),
            .i_right_le    (right_le),
            .i_rank        (CW'(i + 1)),
            .o_sample      (w_sample[i]),
            .o_gt          (w_gt[i]),
            .o_le          (w_le[i]),
            .o_word        (w_word[i])
        );
    end

    // ---------------- rank fold: OR eight words into one per cycle ----------------
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            fold_src[i] = (r_fold == '0) ? w_word[i] : r_acc[i];
        end
        for (int j = 0; j < CAPACITY; j++) begin
            n_acc[j] = '0;
            if (j < Groups) begin
                for (int k = 0; k < 8; k++) begin
                    if (8 * j + k < CAPACITY) begin
                        n_acc[j] = n_acc[j] | fold_src[8 * j + k];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FOLD && r_fold != FoldW'(FoldSteps)) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_acc[i] <= n_acc[i];
            end
        end
    end

    assign div_start = (r_state == ST_FOLD) && (r_fold == FoldW'(FoldSteps));

    cdf_div #(
        .CNT_W  (CW),
        .FRAC_W (FB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_count (r_acc[0]),
        .i_total (r_total),
        .o_done  (div_done),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_fold      <= '0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_action <= i_s_tuser;
                        r_key    <= i_s_tdata;
                        r_state  <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_res_status <= STATUS_OK;
                    r_res_count  <= '0;
                    r_res_frac   <= '0;
                    r_state      <= ST_DONE;
                    unique case (r_action)
                        ACT_CLEAR: r_total <= '0;
                        ACT_ADD: begin
                            if (full) begin
                                r_res_status <= STATUS_FULL;
                            end else begin
                                r_total <= r_total + 1'b1;
                            end
                        end
                        ACT_QUERY: begin
                            if (r_total == '0) begin
                                r_res_status <= STATUS_EMPTY;
                            end else begin
                                r_fold  <= '0;
                                r_state <= ST_FOLD;
                            end
                        end
                        ACT_NOP: ;
                        default: ;
                    endcase
                end
                ST_FOLD: begin
                    if (div_start) begin
                        r_res_count <= r_acc[0];
                        r_state     <= ST_DIV;
                    end else begin
                        r_fold <= r_fold + 1'b1;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_res_frac <= div_quot;
                        r_state    <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_count  <= r_res_count;
                        r_out_frac   <= r_res_frac;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_tready = r_state == ST_IDLE;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = OutDataW'({r_out_frac, r_out_count});

    // ---------------- checks ----------------
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(CAPACITY))
        else $error("sample total above capacity");

    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> (r_state == ST_DIV))
        else $error("divider running outside its state");

    a_frac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_frac <= ((FB + 1)'(1) << FB)))
        else $error("fraction above one");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != STATUS_OK) |-> (r_out_count == '0 && r_out_frac == '0))
        else $error("flagged word carries a count");

endmodule
